@@ hw/rtl/srrh_pkg.sv @@
// ----------------------------------------------------------------------------
// srrh_pkg
// Types, constants and a rotate helper for the reduced-round SHA-256 hasher.
// ----------------------------------------------------------------------------
package srrh_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       count_byte;
    logic       start_comp;
    logic       round;
    logic       fold;
    logic       init;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0]  block_position;
    logic [60:0] byte_count;
    logic [6:0]  rounds;
  } dp_stat_t;

  localparam logic [6:0] FULL_ROUNDS = 7'd64;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ hw/rtl/srrh_datapath.sv @@
// ----------------------------------------------------------------------------
// srrh_datapath
// Block buffer, chaining hash, working variables, counters and one round unit.
// ----------------------------------------------------------------------------
module srrh_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [6:0]        cfg_data,
  input  srrh_pkg::dp_cmd_t cmd,
  input  logic [2:0]        rd_index,
  output srrh_pkg::dp_stat_t stat,
  output logic [31:0]       rd_word
);

  logic [31:0] chain [8];
  logic [31:0] wv [8];
  logic [31:0] w [16];
  logic [5:0]  block_position;
  logic [60:0] byte_count;
  logic [6:0]  round_count;
  logic [5:0]  t;

  logic [3:0]  j;
  logic [31:0] a, b, s0, s1, wj, e1, chs, e0, maj, tmp1;
  logic [3:0]  bidx;
  logic [4:0]  bsh;

  always_comb begin
    j    = t[3:0];
    a    = w[j + 4'd1];
    b    = w[j + 4'd14];
    s0   = srrh_pkg::rotr(a, 7) ^ srrh_pkg::rotr(a, 18) ^ (a >> 3);
    s1   = srrh_pkg::rotr(b, 17) ^ srrh_pkg::rotr(b, 19) ^ (b >> 10);
    wj   = (t >= 6'd16) ? (w[j] + s0 + w[j + 4'd9] + s1) : w[j];
    e1   = srrh_pkg::rotr(wv[4], 6) ^ srrh_pkg::rotr(wv[4], 11) ^ srrh_pkg::rotr(wv[4], 25);
    chs  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    e0   = srrh_pkg::rotr(wv[0], 2) ^ srrh_pkg::rotr(wv[0], 13) ^ srrh_pkg::rotr(wv[0], 22);
    maj  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    tmp1 = wv[7] + e1 + chs + srrh_pkg::RK[t] + wj;
    bidx = block_position[5:2];
    bsh  = 5'd24 - {block_position[1:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count    <= srrh_pkg::FULL_ROUNDS;
      block_position <= '0;
      byte_count     <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= srrh_pkg::IV[i];
    end else begin
      if (cfg_valid) round_count <= cfg_data;
      if (cmd.load_byte) begin
        w[bidx] <= (w[bidx] & ~(32'hff << bsh)) | ({24'd0, cmd.byte_val} << bsh);
        block_position <= block_position + 6'd1;
      end
      if (cmd.count_byte) byte_count <= byte_count + 61'd1;
      if (cmd.start_comp) begin
        t <= '0;
        for (int i = 0; i < 8; i++) wv[i] <= chain[i];
      end
      if (cmd.round) begin
        w[j]  <= wj;
        t     <= t + 6'd1;
        wv[7] <= wv[6];
        wv[6] <= wv[5];
        wv[5] <= wv[4];
        wv[4] <= wv[3] + tmp1;
        wv[3] <= wv[2];
        wv[2] <= wv[1];
        wv[1] <= wv[0];
        wv[0] <= tmp1 + e0 + maj;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
      end
      if (cmd.init) begin
        block_position <= '0;
        byte_count     <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= srrh_pkg::IV[i];
      end
    end
  end

  assign stat.block_position = block_position;
  assign stat.byte_count     = byte_count;
  assign stat.rounds = (round_count > srrh_pkg::FULL_ROUNDS) ? srrh_pkg::FULL_ROUNDS
                                                             : round_count;
  assign rd_word = chain[rd_index];

endmodule

@@ hw/rtl/srrh_control.sv @@
// ----------------------------------------------------------------------------
// srrh_control
// Sequencer for byte loading, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module srrh_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srrh_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srrh_pkg::out_word_t out_data,
  output srrh_pkg::dp_cmd_t   cmd,
  input  srrh_pkg::dp_stat_t  stat,
  output logic [2:0]          rd_index,
  input  logic [31:0]         rd_word
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state, state_next;
  logic        ending, ending_next;
  logic        pad_first, pad_first_next;
  logic        zero_block, zero_block_next;
  logic        len_done, len_done_next;
  logic [6:0]  rcnt, rcnt_next;
  logic [63:0] bits, bits_next;
  logic [2:0]  oidx, oidx_next;
  logic        wraps, accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign wraps     = (stat.block_position == 6'd63);
  assign rd_index  = oidx;
  assign out_valid = (state == S_OUT);
  assign out_data.digest_word = rd_word;
  assign out_data.word_index  = oidx;
  assign out_data.last_word   = (oidx == 3'd7);

  always_comb begin
    state_next      = state;
    ending_next     = ending;
    pad_first_next  = pad_first;
    zero_block_next = zero_block;
    len_done_next   = len_done;
    rcnt_next       = rcnt;
    bits_next       = bits;
    oidx_next       = oidx;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.byte_val    = in_data.msg_byte;
          cmd.load_byte   = in_data.byte_present;
          cmd.count_byte  = in_data.byte_present;
          ending_next     = in_data.end_of_message;
          pad_first_next  = 1'b1;
          zero_block_next = 1'b0;
          len_done_next   = 1'b0;
          if (in_data.byte_present) begin
            bits_next = {stat.byte_count + 61'd1, 3'b000};
          end else begin
            bits_next = {stat.byte_count, 3'b000};
          end
          if (in_data.byte_present && wraps) state_next = S_START;
          else if (in_data.end_of_message) state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.load_byte = 1'b1;
        if (pad_first) begin
          cmd.byte_val    = srrh_pkg::PAD_BYTE;
          zero_block_next = (stat.block_position >= srrh_pkg::LEN_POS) && !wraps;
        end else if (stat.block_position >= srrh_pkg::LEN_POS && !zero_block) begin
          cmd.byte_val = bits[63:56];
          bits_next    = {bits[55:0], 8'd0};
        end else begin
          cmd.byte_val = 8'd0;
        end
        pad_first_next = 1'b0;
        if (wraps) begin
          state_next = S_START;
          if (!pad_first) begin
            zero_block_next = 1'b0;
            len_done_next   = !zero_block;
          end
        end
      end
      S_START: begin
        cmd.start_comp = 1'b1;
        rcnt_next      = stat.rounds;
        state_next     = S_ROUND;
      end
      S_ROUND: begin
        if (rcnt == 7'd0) begin
          state_next = S_FOLD;
        end else begin
          cmd.round = 1'b1;
          rcnt_next = rcnt - 7'd1;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        oidx_next = '0;
        priority if (!ending) state_next = S_IDLE;
        else if (!len_done) state_next = S_PAD;
        else state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_next = oidx + 3'd1;
          if (oidx == 3'd7) begin
            cmd.init   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ending     <= 1'b0;
      pad_first  <= 1'b0;
      zero_block <= 1'b0;
      len_done   <= 1'b0;
      rcnt       <= '0;
      oidx       <= '0;
      bits       <= '0;
    end else begin
      state      <= state_next;
      ending     <= ending_next;
      pad_first  <= pad_first_next;
      zero_block <= zero_block_next;
      len_done   <= len_done_next;
      rcnt       <= rcnt_next;
      oidx       <= oidx_next;
      bits       <= bits_next;
    end
  end

endmodule

@@ hw/rtl/sha256_reduced_round_hash_top.sv @@
// ----------------------------------------------------------------------------
// sha256_reduced_round_hash_top
// Byte-serial SHA-256 with configurable rounds per block.
//
//   channel | signals                          | carries
//   in      | in_valid in_ready in_data        | one message byte / end flag
//   out     | out_valid out_ready out_data     | one digest word
//   cfg     | cfg_valid cfg_ready cfg_data     | round count
//
// Bytes are taken only while idle; a full block then runs start, rounds and fold in the round unit.
// An end word adds the padding bytes, a compression per padded block,
// then eight digest words. One item in flight; a stalled digest holds.
// Reset loads the initial hash vector and 64 rounds.
// ----------------------------------------------------------------------------
module sha256_reduced_round_hash_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srrh_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srrh_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  srrh_pkg::dp_cmd_t  cmd;
  srrh_pkg::dp_stat_t stat;
  logic [2:0]         rd_index;
  logic [31:0]        rd_word;

  assign cfg_ready = 1'b1;

  srrh_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cmd, .stat, .rd_index, .rd_word
  );

  srrh_datapath u_dp (
    .clk, .rst, .cfg_valid, .cfg_data, .cmd, .rd_index, .stat, .rd_word
  );

endmodule

@@ hw/rtl/srrh_checker.sv @@
// ----------------------------------------------------------------------------
// srrh_checker
// Port-level checks for the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module srrh_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input srrh_pkg::out_word_t out_data
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during digest");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest index skipped");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag mismatch");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest dropped under stall");

endmodule

bind sha256_reduced_round_hash_top srrh_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
